FILE: hdl/cdir_pkg.sv
// shared constants and types for the crystal direction index reducer
// no dependencies
`default_nettype none

package cdir_pkg;

	localparam int DEF_INDEX_WIDTH = 16;
	localparam int NUM_MAG         = 7;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FETCH = 6'b000010,
		S_EUC   = 6'b000100,
		S_DIV   = 6'b001000,
		S_POST  = 6'b010000,
		S_QNEXT = 6'b100000
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/crystal_direction_index_reducer.sv
// four-index to three-index crystal direction reducer, gcd reduction of both groups
// depends on cdir_pkg
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+------------------------------
//   input    | index_u index_v index_t index_w           | taken when start && !busy
//   result   | four_u..four_w dir_u..dir_w flags         | valid one cycle with done
//
// one shared restoring divider (one quotient bit a cycle) does every euclid
// remainder step and up to seven exact divisions, one for each quotient whose
// group divisor is nonzero; done rises in the same cycle that busy falls
// busy stays high for the whole word; the receiver cannot stall, done marks
// the result for one cycle; arst_n clears the sequencer and done
`default_nettype none

module crystal_direction_index_reducer #(
	parameter int INDEX_WIDTH = cdir_pkg::DEF_INDEX_WIDTH
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire  signed [INDEX_WIDTH-1:0] index_u,
	input  wire  signed [INDEX_WIDTH-1:0] index_v,
	input  wire  signed [INDEX_WIDTH-1:0] index_t,
	input  wire  signed [INDEX_WIDTH-1:0] index_w,
	output logic                          done,
	output logic signed [INDEX_WIDTH-1:0] four_u,
	output logic signed [INDEX_WIDTH-1:0] four_v,
	output logic signed [INDEX_WIDTH-1:0] four_t,
	output logic signed [INDEX_WIDTH-1:0] four_w,
	output logic signed [INDEX_WIDTH:0]   dir_u,
	output logic signed [INDEX_WIDTH:0]   dir_v,
	output logic signed [INDEX_WIDTH-1:0] dir_w,
	output logic                          reducible,
	output logic                          four_zero_error,
	output logic                          dir_zero_error
);

	localparam int W  = INDEX_WIDTH;
	localparam int CW = $clog2(W);
	localparam int NM = cdir_pkg::NUM_MAG;

	cdir_pkg::state_t state_q;

	logic [W-1:0]    mag_q [0:NM-1];
	logic [NM-1:0]   neg_q;
	logic [2:0]      k_q;
	logic [W-1:0]    a_q, b_q, g4_q, g3_q;
	logic [W-1:0]    rem_q, quo_q;
	logic [CW-1:0]   cnt_q;
	logic            quot_mode_q;
	logic            done_q;

	logic [W-1:0]    four_u_q, four_v_q, four_t_q, four_w_q, dir_w_q;
	logic [W:0]      dir_u_q, dir_v_q;

	logic signed [W:0] du, dv;
	logic [W-1:0]    mag_u, mag_v, mag_t, mag_w, mag_du, mag_dv;
	logic [W-1:0]    mag_sel, g_sel;
	logic [W:0]      shifted;
	logic [W+1:0]    diff;
	logic [W-1:0]    q_val;
	logic            neg_sel;
	logic [W-1:0]    res_n;
	logic [W:0]      res_w;

	function automatic logic [W-1:0] mag_n(input logic [W-1:0] x);
		logic [W-1:0] r;
		r = x[W-1] ? (~x + W'(1)) : x;
		return r;
	endfunction

	function automatic logic [W-1:0] mag_w1(input logic [W:0] x);
		logic [W:0] r;
		r = x[W] ? (~x + (W+1)'(1)) : x;
		return r[W-1:0];
	endfunction

	always_comb begin
		du      = {index_u[W-1], index_u} - {index_t[W-1], index_t};
		dv      = {index_v[W-1], index_v} - {index_t[W-1], index_t};
		mag_u   = mag_n(index_u);
		mag_v   = mag_n(index_v);
		mag_t   = mag_n(index_t);
		mag_w   = mag_n(index_w);
		mag_du  = mag_w1(du);
		mag_dv  = mag_w1(dv);
		mag_sel = (k_q < 3'(NM)) ? mag_q[k_q] : '0;
		neg_sel = (k_q < 3'(NM)) ? neg_q[k_q] : 1'b0;
		g_sel   = (k_q < 3'd4) ? g4_q : g3_q;
		shifted = {rem_q, quo_q[W-1]};
		diff    = {1'b0, shifted} - {2'b00, b_q};
		q_val   = (state_q == cdir_pkg::S_POST) ? quo_q : '0;
		res_n   = neg_sel ? (~q_val + W'(1)) : q_val;
		res_w   = neg_sel ? (~{1'b0, q_val} + (W+1)'(1)) : {1'b0, q_val};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= cdir_pkg::S_IDLE;
			done_q          <= 1'b0;
			k_q             <= '0;
			quot_mode_q     <= 1'b0;
			cnt_q           <= '0;
			for (int i = 0; i < NM; i++)
				mag_q[i] <= '0;
			neg_q           <= '0;
			a_q             <= '0;
			b_q             <= '0;
			g4_q            <= '0;
			g3_q            <= '0;
			rem_q           <= '0;
			quo_q           <= '0;
			four_zero_error <= 1'b0;
			reducible       <= 1'b0;
			dir_zero_error  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				cdir_pkg::S_IDLE: begin
					if (start) begin
						mag_q[0]    <= mag_u;
						mag_q[1]    <= mag_v;
						mag_q[2]    <= mag_t;
						mag_q[3]    <= mag_w;
						mag_q[4]    <= mag_du;
						mag_q[5]    <= mag_dv;
						mag_q[6]    <= mag_w;
						neg_q       <= {index_w[W-1], dv[W], du[W], index_w[W-1],
							index_t[W-1], index_v[W-1], index_u[W-1]};
						a_q         <= mag_u;
						k_q         <= 3'd1;
						quot_mode_q <= 1'b0;
						state_q     <= cdir_pkg::S_FETCH;
					end
				end
				cdir_pkg::S_FETCH: begin
					b_q     <= mag_sel;
					state_q <= cdir_pkg::S_EUC;
				end
				cdir_pkg::S_EUC: begin
					if (b_q != '0) begin
						rem_q   <= '0;
						quo_q   <= a_q;
						cnt_q   <= '0;
						state_q <= cdir_pkg::S_DIV;
					end else if (k_q == 3'd3) begin
						g4_q    <= a_q;
						a_q     <= mag_q[4];
						k_q     <= 3'd5;
						state_q <= cdir_pkg::S_FETCH;
					end else if (k_q == 3'd6) begin
						g3_q        <= a_q;
						k_q         <= '0;
						quot_mode_q <= 1'b1;
						state_q     <= cdir_pkg::S_QNEXT;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= cdir_pkg::S_FETCH;
					end
				end
				cdir_pkg::S_DIV: begin
					// restoring step: shift in next dividend bit, subtract divisor
					if (!diff[W+1]) begin
						rem_q <= diff[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= shifted[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(W-1))
						state_q <= cdir_pkg::S_POST;
				end
				cdir_pkg::S_POST: begin
					if (quot_mode_q) begin
						k_q     <= k_q + 3'd1;
						state_q <= cdir_pkg::S_QNEXT;
					end else begin
						a_q     <= b_q;
						b_q     <= rem_q;
						state_q <= cdir_pkg::S_EUC;
					end
				end
				cdir_pkg::S_QNEXT: begin
					if (k_q == 3'd7) begin
						four_zero_error <= (g4_q == '0);
						reducible       <= (g4_q > W'(1));
						dir_zero_error  <= (g3_q == '0);
						done_q          <= 1'b1;
						state_q         <= cdir_pkg::S_IDLE;
					end else if (g_sel == '0) begin
						k_q <= k_q + 3'd1;
					end else begin
						b_q     <= g_sel;
						quo_q   <= mag_sel;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= cdir_pkg::S_DIV;
					end
				end
				default: begin
					state_q <= cdir_pkg::S_IDLE;
				end
			endcase
		end
	end

	// result write, zero when the group divisor is zero
	always_ff @(posedge clk) begin
		if ((state_q == cdir_pkg::S_POST && quot_mode_q) ||
			(state_q == cdir_pkg::S_QNEXT && k_q != 3'd7 && g_sel == '0)) begin
			case (k_q)
				3'd0:    four_u_q <= res_n;
				3'd1:    four_v_q <= res_n;
				3'd2:    four_t_q <= res_n;
				3'd3:    four_w_q <= res_n;
				3'd4:    dir_u_q  <= res_w;
				3'd5:    dir_v_q  <= res_w;
				3'd6:    dir_w_q  <= res_n;
				default: dir_w_q  <= dir_w_q;
			endcase
		end
	end

	assign busy   = (state_q != cdir_pkg::S_IDLE);
	assign done   = done_q;
	assign four_u = four_u_q;
	assign four_v = four_v_q;
	assign four_t = four_t_q;
	assign four_w = four_w_q;
	assign dir_u  = dir_u_q;
	assign dir_v  = dir_v_q;
	assign dir_w  = dir_w_q;

endmodule

`default_nettype wire

FILE: sim/cdir_checker.sv
`timescale 1ns / 1ps
// scoreboard for the crystal direction index reducer: predicts each result word from the
// accepted index word (gcd reduction of both groups) and compares it field by field
// depends on cdir_pkg
module cdir_checker #(
	parameter int W = cdir_pkg::DEF_INDEX_WIDTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire                 busy,
	input  wire  signed [W-1:0] index_u,
	input  wire  signed [W-1:0] index_v,
	input  wire  signed [W-1:0] index_t,
	input  wire  signed [W-1:0] index_w,
	input  wire                 done,
	input  wire  signed [W-1:0] four_u,
	input  wire  signed [W-1:0] four_v,
	input  wire  signed [W-1:0] four_t,
	input  wire  signed [W-1:0] four_w,
	input  wire  signed [W:0]   dir_u,
	input  wire  signed [W:0]   dir_v,
	input  wire  signed [W-1:0] dir_w,
	input  wire                 reducible,
	input  wire                 four_zero_error,
	input  wire                 dir_zero_error,
	output int                  errors,
	output int                  pending,
	output int                  checked,
	output int                  reducible_hits,
	output int                  zero_hits
);

	typedef struct {
		logic signed [W-1:0] four_u;
		logic signed [W-1:0] four_v;
		logic signed [W-1:0] four_t;
		logic signed [W-1:0] four_w;
		logic signed [W:0]   dir_u;
		logic signed [W:0]   dir_v;
		logic signed [W-1:0] dir_w;
		logic                reducible;
		logic                four_zero;
		logic                dir_zero;
	} reduced_dir_t;

	reduced_dir_t expected_dirs[$];
	int mismatches = 0;
	int n_checked = 0;
	int n_reducible = 0;
	int n_zero = 0;

	function automatic longint unsigned mag(longint x);
		return (x < 0) ? longint'(-x) : x;
	endfunction

	function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
		longint unsigned r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic longint quot(longint x, longint unsigned g);
		longint unsigned q;
		q = mag(x) / g;
		return (x < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic reduced_dir_t reduce_direction(input logic signed [W-1:0] u,
		input logic signed [W-1:0] v, input logic signed [W-1:0] t,
		input logic signed [W-1:0] w);
		reduced_dir_t r;
		longint su, sv, st, sw, du, dv;
		longint unsigned g4, g3;
		su = longint'(u);
		sv = longint'(v);
		st = longint'(t);
		sw = longint'(w);
		du = su - st;
		dv = sv - st;
		r.four_u = '0;
		r.four_v = '0;
		r.four_t = '0;
		r.four_w = '0;
		r.dir_u = '0;
		r.dir_v = '0;
		r.dir_w = '0;
		r.reducible = 1'b0;
		r.four_zero = 1'b0;
		r.dir_zero = 1'b0;
		g4 = gcd_of(gcd_of(gcd_of(mag(su), mag(sv)), mag(st)), mag(sw));
		if (g4 == 0) begin
			r.four_zero = 1'b1;
		end else begin
			r.four_u = W'(quot(su, g4));
			r.four_v = W'(quot(sv, g4));
			r.four_t = W'(quot(st, g4));
			r.four_w = W'(quot(sw, g4));
			r.reducible = (g4 > 1);
		end
		g3 = gcd_of(gcd_of(mag(du), mag(dv)), mag(sw));
		if (g3 == 0) begin
			r.dir_zero = 1'b1;
		end else begin
			r.dir_u = (W+1)'(quot(du, g3));
			r.dir_v = (W+1)'(quot(dv, g3));
			r.dir_w = W'(quot(sw, g3));
		end
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		reduced_dir_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_dirs.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					want = expected_dirs.pop_front();
					check_field("four_u", want.four_u, four_u);
					check_field("four_v", want.four_v, four_v);
					check_field("four_t", want.four_t, four_t);
					check_field("four_w", want.four_w, four_w);
					check_field("dir_u", want.dir_u, dir_u);
					check_field("dir_v", want.dir_v, dir_v);
					check_field("dir_w", want.dir_w, dir_w);
					check_field("reducible", want.reducible, reducible);
					check_field("four_zero_error", want.four_zero, four_zero_error);
					check_field("dir_zero_error", want.dir_zero, dir_zero_error);
					n_checked++;
					if (want.reducible)
						n_reducible++;
					if (want.four_zero || want.dir_zero)
						n_zero++;
				end
			end
			if (start && !busy)
				expected_dirs.push_back(reduce_direction(index_u, index_v, index_t, index_w));
		end
		errors <= mismatches;
		pending <= expected_dirs.size();
		checked <= n_checked;
		reducible_hits <= n_reducible;
		zero_hits <= n_zero;
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// testbench top for the crystal direction index reducer: drives directed and random
// index words with random idling and gives the verdict
// depends on cdir_pkg, crystal_direction_index_reducer and cdir_checker
module tb;

	localparam int W           = cdir_pkg::DEF_INDEX_WIDTH;
	localparam logic signed [W-1:0] MOST_NEG = W'(-(2 ** (W - 1)));
	localparam logic signed [W-1:0] MOST_POS = W'(2 ** (W - 1) - 1);
	localparam int RANDOM_WORDS = 1330;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic signed [W-1:0] index_u, index_v, index_t, index_w;
	wire busy, done;
	wire signed [W-1:0] four_u, four_v, four_t, four_w, dir_w;
	wire signed [W:0] dir_u, dir_v;
	wire reducible, four_zero_error, dir_zero_error;
	int errors, pending, checked, reducible_hits, zero_hits;
	int words_sent = 0;
	int stall_cycles = 0;
	logic quiet = 1'b0;

	always #5 clk = ~clk;

	crystal_direction_index_reducer #(.INDEX_WIDTH(W)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.index_u(index_u), .index_v(index_v), .index_t(index_t), .index_w(index_w),
		.done(done), .four_u(four_u), .four_v(four_v), .four_t(four_t), .four_w(four_w),
		.dir_u(dir_u), .dir_v(dir_v), .dir_w(dir_w), .reducible(reducible),
		.four_zero_error(four_zero_error), .dir_zero_error(dir_zero_error)
	);

	cdir_checker #(.W(W)) scoreboard (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.index_u(index_u), .index_v(index_v), .index_t(index_t), .index_w(index_w),
		.done(done), .four_u(four_u), .four_v(four_v), .four_t(four_t), .four_w(four_w),
		.dir_u(dir_u), .dir_v(dir_v), .dir_w(dir_w), .reducible(reducible),
		.four_zero_error(four_zero_error), .dir_zero_error(dir_zero_error),
		.errors(errors), .pending(pending), .checked(checked),
		.reducible_hits(reducible_hits), .zero_hits(zero_hits)
	);

	function automatic logic offer();
		return quiet || ($urandom_range(99) >= 23);
	endfunction

	function automatic logic signed [W-1:0] edge_value();
		case ($urandom_range(0, 5))
			0: return MOST_NEG;
			1: return MOST_NEG + W'(1);
			2: return W'(-1);
			3: return '0;
			4: return W'(1);
			default: return MOST_POS;
		endcase
	endfunction

	task automatic push_word(input logic signed [W-1:0] u, input logic signed [W-1:0] v,
		input logic signed [W-1:0] t, input logic signed [W-1:0] w);
		logic taken;
		taken = 1'b0;
		index_u <= u;
		index_v <= v;
		index_t <= t;
		index_w <= w;
		start <= offer();
		while (!taken) begin
			@(posedge clk);
			if (start && !busy)
				taken = 1'b1;
			else
				start <= offer();
		end
		words_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int k, f;
		int a, b;
		logic signed [W-1:0] u, v, t, w;
		arst_n = 1'b0;
		start = 1'b0;
		index_u = '0;
		index_v = '0;
		index_t = '0;
		index_w = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words: zero divisors, most negative values, long euclid chains
		push_word(0, 0, 0, 0);
		push_word(5, 5, 5, 0);
		push_word(MOST_NEG, MOST_NEG, MOST_NEG, 0);
		push_word(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
		push_word(MOST_NEG, 1, 0, 0);
		push_word(MOST_POS, MOST_NEG, MOST_POS, MOST_NEG);
		push_word(MOST_NEG, MOST_POS, MOST_POS, 0);
		push_word(MOST_POS, 0, MOST_NEG, 1);
		push_word(MOST_POS, MOST_POS, MOST_POS, MOST_POS);
		push_word(-1, -1, -1, -1);
		push_word(2, -1, -1, 0);
		push_word(1, 1, -2, 0);
		push_word(2, 4, -6, 8);
		push_word(0, 0, 0, 1);
		push_word(0, 0, 0, MOST_NEG);
		push_word(28657, 17711, 10946, 6765);
		push_word(0, 7, 0, 0);
		push_word(-6, 9, -3, 12);
		push_word(12, -4, -8, 16);
		drain();

		for (k = 0; k < RANDOM_WORDS; k++) begin
			quiet = (k >= 500 && k < 850);
			if (k == 1000)
				drain();
			if (!quiet && $urandom_range(99) < 4) begin
				repeat ($urandom_range(1, 40)) begin
					start <= 1'b0;
					index_u <= W'($urandom);
					index_v <= W'($urandom);
					index_t <= W'($urandom);
					index_w <= W'($urandom);
					@(posedge clk);
				end
			end
			f = $urandom_range(99);
			if (f < 30) begin
				u = W'($urandom);
				v = W'($urandom);
				t = W'($urandom);
				w = W'($urandom);
			end else if (f < 40) begin
				u = edge_value();
				v = edge_value();
				t = edge_value();
				w = edge_value();
			end else if (f < 65) begin
				// well-formed four-index direction with u + v + t = 0
				a = int'($urandom_range(0, 32000)) - 16000;
				b = int'($urandom_range(0, 32000)) - 16000;
				u = W'(a);
				v = W'(b);
				t = W'(-(a + b));
				w = W'($urandom);
			end else if (f < 85) begin
				a = int'($urandom_range(1, 511));
				u = W'((int'($urandom_range(0, 128)) - 64) * a);
				v = W'((int'($urandom_range(0, 128)) - 64) * a);
				t = W'((int'($urandom_range(0, 128)) - 64) * a);
				w = W'((int'($urandom_range(0, 128)) - 64) * a);
			end else begin
				u = W'(int'($urandom_range(0, 16)) - 8);
				v = W'(int'($urandom_range(0, 16)) - 8);
				t = W'(int'($urandom_range(0, 16)) - 8);
				w = W'(int'($urandom_range(0, 16)) - 8);
			end
			push_word(u, v, t, w);
		end

		drain();
		repeat (2000) @(posedge clk);
		$display("%0d index words sent, %0d result words checked", words_sent, checked);
		$display("%0d reducible, %0d with a zero divisor group", reducible_hits, zero_hits);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
